// ===== rtl/core/los_pkg.sv =====
// Package for the line-of-sight bitmap walk: sizes, item types and state codes.
// No dependencies.
`timescale 1ns / 1ps
package los_pkg;
    localparam int unsigned MAX_MAP_WIDTH  = 256;
    localparam int unsigned MAX_MAP_HEIGHT = 256;
    localparam int unsigned XW = $clog2(MAX_MAP_WIDTH);
    localparam int unsigned YW = $clog2(MAX_MAP_HEIGHT);
    localparam int unsigned AW = XW + YW;
    localparam int unsigned STORE_BITS = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] REG_PPM = 2'd0;
    localparam logic [1:0] REG_W   = 2'd1;
    localparam logic [1:0] REG_H   = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [15:0] pixel_addr;
        logic [7:0]  pixel_value;
        logic [15:0] tx_x;
        logic [15:0] tx_y;
        logic [15:0] rx_x;
        logic [15:0] rx_y;
    } t_in_item;

    typedef struct packed {
        logic line_clear;
        logic off_map;
    } t_out_item;

    // classified item held in the queue between front and back
    typedef struct packed {
        logic        is_load;
        logic        trivial;
        logic        wr_ok;
        logic        wr_bit;
        logic [15:0] addr;
        logic [15:0] tx_x;
        logic [15:0] tx_y;
        logic [15:0] rx_x;
        logic [15:0] rx_y;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_SQRT, ST_DIVX, ST_DIVY, ST_TGT, ST_TGT2, ST_ADDR,
        ST_READ, ST_TEST, ST_STEP, ST_DIST, ST_DONE
    } t_state;
endpackage

// ===== rtl/core/los_if.sv =====
// Valid/ready channel interfaces for items and configuration writes.
// Depends on los_pkg.
`timescale 1ns / 1ps
interface los_in_if;
    import los_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface los_out_if;
    import los_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface los_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/line_of_sight_bitmap_walk.sv =====
// Line-of-sight walk over a one-bit obstruction bitmap.
// A load writes one bitmap bit (if its address is in range) and gives no result; a query
// runs a square root and two divisions for setup, then walks pixel by pixel (one bitmap read per step).
// Throughput: one item at a time in the back end; a two-entry queue decouples it.
// Reset (synchronous, active low) clears control state and sets the configuration
// defaults; data registers and the bitmap are undefined until written.
`timescale 1ns / 1ps
module line_of_sight_bitmap_walk
    import los_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    los_in_if.sink   in_ch,
    los_out_if.source out_ch,
    los_cfg_if.sink  cfg_ch
);
    logic       fq_valid, fq_ready;
    t_job       fq_job;
    logic [4:0] ppm;
    logic [8:0] w, h;

    los_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(cfg_ch.valid),
        .i_index(cfg_ch.index), .i_wdata(cfg_ch.wdata), .o_ready(cfg_ch.ready),
        .o_ppm(ppm), .o_w(w), .o_h(h)
    );

    los_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_ch.valid), .o_ready(in_ch.ready),
        .i_item(in_ch.data), .o_valid(fq_valid), .i_ready(fq_ready), .o_job(fq_job)
    );

    los_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(fq_valid), .o_ready(fq_ready),
        .i_job(fq_job), .i_ppm(ppm), .i_w(w), .i_h(h),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready), .o_item(out_ch.data)
    );
endmodule

// ===== rtl/core/los_front.sv =====
// Front end: accepts items, classifies loads and queries, queues them.
// Depends on los_pkg.
`timescale 1ns / 1ps
module los_front
    import los_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_ready,
    output t_job     o_job
);
    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job       n_job;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rp];

    // classify
    always_comb begin
        n_job.is_load = (i_item.cmd == CMD_LOAD);
        n_job.trivial = (i_item.tx_x == i_item.rx_x) && (i_item.tx_y == i_item.rx_y);
        n_job.wr_ok   = (32'(i_item.pixel_addr) < STORE_BITS);
        n_job.wr_bit  = (i_item.pixel_value != 8'd0);
        n_job.addr    = i_item.pixel_addr;
        n_job.tx_x    = i_item.tx_x;
        n_job.tx_y    = i_item.tx_y;
        n_job.rx_x    = i_item.rx_x;
        n_job.rx_y    = i_item.rx_y;
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_ready) else $error("ready while full");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp) else $error("pointer mismatch");
endmodule

// ===== rtl/core/los_div.sv =====
// Shared iterative unit: restoring divide (one quotient bit a cycle) and
// integer square root (one root bit a cycle). No package dependency beyond los_pkg.
`timescale 1ns / 1ps
module los_div
    import los_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_sqrt,
    input  logic [49:0] i_num,
    input  logic [49:0] i_den,
    output logic        o_done,
    output logic [49:0] o_res
);
    logic [49:0] r_v, r_r, r_b, r_d, r_q, r_rem;
    logic [5:0]  r_n;
    logic        r_busy, r_sq;
    logic [50:0] n_trial;
    logic [49:0] rb;

    assign rb      = r_r + r_b;
    assign n_trial = {r_rem[49:0], r_v[49]} - {1'b0, r_d};
    assign o_res   = r_sq ? r_r : r_q;

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1; r_sq <= i_sqrt;
            r_v <= i_num; r_d <= i_den; r_r <= '0; r_q <= '0; r_rem <= '0;
            r_b <= 50'h1_0000_0000_0000;
            r_n <= i_sqrt ? 6'd25 : 6'd50;
        end else if (r_busy) begin
            if (r_sq) begin
                // one result bit per cycle
                if (r_v >= rb) begin
                    r_v <= r_v - rb; r_r <= (r_r >> 1) + r_b;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_b <= r_b >> 2;
            end else begin
                r_v <= r_v << 1;
                if (!n_trial[50]) begin
                    r_rem <= n_trial[49:0]; r_q <= {r_q[48:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[48:0], r_v[49]}; r_q <= {r_q[48:0], 1'b0};
                end
            end
            r_n <= r_n - 6'd1;
            if (r_n == 6'd1) begin
                r_busy <= 1'b0; o_done <= 1'b1;
            end
        end
    end
endmodule

// ===== rtl/core/los_back.sv =====
// Back end: holds the obstruction bitmap, runs loads and the line walk.
// Depends on los_pkg and los_div.
`timescale 1ns / 1ps
module los_back
    import los_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_job        i_job,
    input  logic [4:0]  i_ppm,
    input  logic [8:0]  i_w,
    input  logic [8:0]  i_h,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item
);
    logic r_map [STORE_BITS];
    logic r_rd;

    t_state r_st, n_st;
    t_job   r_j;
    logic   r_sx, r_sy, r_unb;
    logic [16:0] r_adx, r_ady;
    logic [33:0] r_s, n_s;
    logic [49:0] r_len;
    logic [17:0] r_ux, r_uy;
    logic [43:0] r_tgt;
    logic [32:0] r_x0, r_y0;
    logic [35:0] r_ox, r_oy;
    logic [33:0] r_dist;     // pixels^2 in Q.8 (dist >> 24)
    logic [AW-1:0] r_addr;
    logic        r_clr, r_off;

    logic        dv_start, dv_sqrt, dv_done;
    logic [49:0] dv_num, dv_den, dv_res;
    logic signed [37:0] px, py;
    logic [21:0] xi, yi;
    logic        outside;
    logic [8:0]  w_eff, h_eff;
    logic [16:0] dx_full, dy_full;

    los_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dv_start), .i_sqrt(dv_sqrt),
        .i_num(dv_num), .i_den(dv_den), .o_done(dv_done), .o_res(dv_res)
    );

    assign w_eff = (i_w > 9'(MAX_MAP_WIDTH)) ? 9'(MAX_MAP_WIDTH) : i_w;
    assign h_eff = (i_h > 9'(MAX_MAP_HEIGHT)) ? 9'(MAX_MAP_HEIGHT) : i_h;
    assign dx_full = {1'b0, i_job.rx_x} - {1'b0, i_job.tx_x};
    assign dy_full = {1'b0, i_job.rx_y} - {1'b0, i_job.tx_y};

    // squared span as an unsigned integer (Q.0)
    assign n_s = 34'(r_adx) * 34'(r_adx) + 34'(r_ady) * 34'(r_ady);

    // current position, truncated toward zero
    always_comb begin
        logic [37:0] ax, ay;
        px = $signed({5'd0, r_x0}) + $signed({{2{r_ox[35]}}, r_ox});
        py = $signed({5'd0, r_y0}) + $signed({{2{r_oy[35]}}, r_oy});
        ax = px[37] ? 38'(-px) : 38'(px);
        ay = py[37] ? 38'(-py) : 38'(py);
        xi = ax[37:16];
        yi = ay[37:16];
        outside = (px[37] && xi != 22'd0) || (py[37] && yi != 22'd0)
               || (xi >= 22'(w_eff)) || (yi >= 22'(h_eff));
    end

    assign o_ready = (r_st == ST_IDLE);

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (i_valid && o_ready && !i_job.is_load)
                         n_st = (i_job.trivial || i_ppm == 5'd0) ? ST_DONE : ST_SQ;
            ST_SQ:   n_st = ST_SQRT;
            ST_SQRT: if (dv_done) n_st = ST_DIVX;
            ST_DIVX: if (dv_done) n_st = ST_DIVY;
            ST_DIVY: if (dv_done) n_st = ST_TGT;
            ST_TGT:  n_st = ST_TGT2;
            ST_TGT2: n_st = ST_ADDR;
            ST_ADDR: n_st = (r_unb || 44'(r_dist) < r_tgt) ? ST_READ : ST_DONE;
            ST_READ: n_st = outside ? ST_DONE : ST_TEST;
            ST_TEST: n_st = r_rd ? ST_DONE : ST_STEP;
            ST_STEP: n_st = ST_DIST;
            ST_DIST: n_st = ST_ADDR;
            ST_DONE: n_st = (!o_valid || i_ready) ? ST_IDLE : ST_DONE;
            default: n_st = ST_IDLE;
        endcase
    end

    // divider control
    always_comb begin
        dv_start = 1'b0; dv_sqrt = 1'b0; dv_num = '0; dv_den = 50'd1;
        unique case (r_st)
            ST_SQ: begin
                dv_start = 1'b1; dv_sqrt = 1'b1; dv_num = {n_s, 16'd0};
            end
            ST_SQRT: if (dv_done) begin
                dv_start = 1'b1; dv_num = {9'd0, r_adx, 24'd0}; dv_den = dv_res;
            end
            ST_DIVX: if (dv_done) begin
                dv_start = 1'b1; dv_num = {9'd0, r_ady, 24'd0}; dv_den = r_len;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready && i_job.is_load && i_job.wr_ok)
            r_map[i_job.addr[AW-1:0]] <= i_job.wr_bit;
        r_rd <= r_map[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; o_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            // result register: refilled once the previous item has gone
            if (r_st == ST_DONE && (!o_valid || i_ready)) begin
                o_valid <= 1'b1;
                o_item.line_clear <= r_clr;
                o_item.off_map <= r_off;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
        end
        unique case (r_st)
            ST_IDLE: begin
                r_j <= i_job; r_clr <= 1'b1; r_off <= 1'b0;
                r_sx <= dx_full[16]; r_sy <= dy_full[16];
                r_adx <= dx_full[16] ? 17'(-dx_full) : dx_full;
                r_ady <= dy_full[16] ? 17'(-dy_full) : dy_full;
            end
            ST_SQ: r_s <= n_s;
            ST_SQRT: if (dv_done) r_len <= dv_res;
            ST_DIVX: if (dv_done) r_ux <= dv_res[17:0];
            ST_DIVY: if (dv_done) begin
                r_uy <= dv_res[17:0];
                r_x0 <= {21'(i_ppm) * 21'(r_j.tx_x), 12'd0};
                r_y0 <= {21'(i_ppm) * 21'(r_j.tx_y), 12'd0};
                r_tgt <= 44'(i_ppm) * 44'(i_ppm);
            end
            ST_TGT: begin
                r_unb <= (44'(r_tgt[9:0]) * 44'(r_s)) >= 44'h10_0000_0000;
                r_tgt <= 44'(r_tgt[9:0]) * 44'(r_s);
                r_ox <= '0; r_oy <= '0; r_dist <= '0;
            end
            ST_TGT2: ;
            ST_ADDR: r_addr <= AW'(yi[YW-1:0] * w_eff + 16'(xi[XW-1:0]));
            ST_READ: if (outside) begin r_clr <= 1'b0; r_off <= 1'b1; end
            ST_TEST: if (r_rd) r_clr <= 1'b0;
            ST_STEP: begin
                r_ox <= r_sx ? r_ox - 36'(r_ux) : r_ox + 36'(r_ux);
                r_oy <= r_sy ? r_oy - 36'(r_uy) : r_oy + 36'(r_uy);
            end
            ST_DIST: begin
                // offsets stay within a map diagonal, well under 2^26 in Q.16
                logic [53:0] d2;
                logic [35:0] a1, b1;
                a1 = r_ox[35] ? 36'(-r_ox) : r_ox;
                b1 = r_oy[35] ? 36'(-r_oy) : r_oy;
                d2 = {27'd0, a1[26:0]} * {27'd0, a1[26:0]}
                   + {27'd0, b1[26:0]} * {27'd0, b1[26:0]};
                r_dist <= 34'(d2[53:24]);
            end
            default: ;
        endcase
    end

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != ST_IDLE |-> !o_ready) else $error("accept while busy");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_DONE |=> o_valid) else $error("result not presented");
    a_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.off_map |-> !o_item.line_clear) else $error("off map but clear");
endmodule

// ===== rtl/core/los_cfg.sv =====
// Configuration register file for scale and map dimensions.
// Depends on los_pkg.
`timescale 1ns / 1ps
module los_cfg
    import los_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [1:0]  i_index,
    input  logic [31:0] i_wdata,
    output logic        o_ready,
    output logic [4:0]  o_ppm,
    output logic [8:0]  o_w,
    output logic [8:0]  o_h
);
    assign o_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ppm <= 5'd1; o_w <= 9'd256; o_h <= 9'd256;
        end else if (i_valid) begin
            unique case (i_index)
                REG_PPM: o_ppm <= i_wdata[4:0];
                REG_W:   o_w   <= i_wdata[8:0];
                REG_H:   o_h   <= i_wdata[8:0];
                default: ;
            endcase
        end
    end
endmodule
